// ===== src/hct_pkg.sv =====
// ----------------------------------------------------------------------------
// Hierarchical completion tracker package
// Request and response layouts, operation and status codes.
// ----------------------------------------------------------------------------
package hct_pkg;

  localparam int ID_W    = 10;
  localparam int GEN_W   = 32;
  localparam int ICNT_W  = 16;
  localparam int FREED_W = 11;
  localparam int STAT_W  = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_DEC   = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_ZERO  = 2'd2
  } status_e;

  // Request payload, first field in the highest bits.
  typedef struct packed {
    logic [2:0]        pad;
    logic [ID_W-1:0]   target_id;
    logic [ICNT_W-1:0] initial_count;
    logic [ID_W-1:0]   parent_ix;
    logic              has_parent;
  } in_data_t;

  // Response payload, first field in the highest bits.
  typedef struct packed {
    logic              pad;
    logic [STAT_W-1:0] status;
    logic [FREED_W-1:0] freed_count;
    logic [GEN_W-1:0]  new_generation;
    logic [ID_W-1:0]   new_id;
  } out_data_t;

endpackage

// ===== src/hierarchical_completion_tracker.sv =====
// ----------------------------------------------------------------------------
// Hierarchical completion tracker
// Pool of trackers with generation, outstanding count and link, free list
// threaded through the links, decrement walks up the parent chain.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser op, tdata request
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata response
//
// All tracker state sits in one memory (generation, count, link per tracker).
// After reset a clearing pass writes every entry, with s_axis_tready
// low. A rejected or out-of-range item is answered straight from
// ST_IDLE; an allocate claims the free head in ST_AHEAD, after bumping the
// parent in ST_APAR when it has one, and a decrement walk does one memory
// read-modify-write per tracker. A result waiting on m_axis holds the next
// finished result in a pending register until the output frees up.
module hierarchical_completion_tracker #(
  parameter int POOL_SIZE = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] has_parent, [10:1] parent index, [26:11] initial_count,
  // [36:27] target_id, [39:37] zero
  input  logic [hct_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] op
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] new_id, [41:10] new_generation, [52:42] freed_count,
  // [54:53] status, [55] zero
  output logic [hct_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  import hct_pkg::*;

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int CW = (LW > ID_W) ? LW : ID_W;
  localparam int EW = 2 * GEN_W + LW;

  localparam logic [LW-1:0] EndMark = LW'(POOL_SIZE);
  localparam logic [CW-1:0] NumC    = CW'(POOL_SIZE);
  localparam logic [IW-1:0] LastIdx = IW'(POOL_SIZE - 1);

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [GEN_W-1:0] cnt;
    logic [LW-1:0]    link;
  } entry_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_APAR  = 6'b000100,
    ST_AHEAD = 6'b001000,
    ST_DEC   = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   clr_idx_q, clr_idx_d;
  logic [LW-1:0]   head_q, head_d;
  logic [ICNT_W-1:0] cnt_q, cnt_d;
  logic [LW-1:0]   parent_q, parent_d;
  logic [IW-1:0]   cur_q, cur_d;
  logic [LW-1:0]   freed_q, freed_d;
  logic            out_valid_q, out_valid_d;
  out_data_t       out_data_q, out_data_d;
  out_data_t       pend_q, pend_d;

  in_data_t        in_d;
  logic            accept;
  logic            out_free;
  logic            done;
  out_data_t       res;
  logic [LW-1:0]   freed_nx;
  logic [GEN_W-1:0] cnt_dec;

  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_addr, wr_addr;
  entry_t          wr_entry, rd_entry;
  logic [EW-1:0]   rd_raw;

  assign in_d     = in_data_t'(s_axis_tdata);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign rd_entry = entry_t'(rd_raw);
  assign cnt_dec  = rd_entry.cnt - GEN_W'(1);
  assign freed_nx = freed_q + LW'(1);

  hct_mem #(
    .DEPTH (POOL_SIZE),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (EW'(wr_entry)),
    .rd_data_o (rd_raw)
  );

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    parent_d  = parent_q;
    cur_d     = cur_q;
    freed_d   = freed_q;
    pend_d    = pend_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_entry  = '0;
    done      = 1'b0;
    res       = '0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_idx_q;
        wr_entry.link = LW'(clr_idx_q) + LW'(1);
        if (clr_idx_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + IW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (op_e'(s_axis_tuser[0]) == OP_ALLOC) begin
            cnt_d = in_d.initial_count;
            if (head_q >= EndMark) begin
              done       = 1'b1;
              res.status = STATUS_EMPTY;
            end else if (in_d.has_parent && (CW'(in_d.parent_ix) < NumC)) begin
              rd_en    = 1'b1;
              rd_addr  = IW'(in_d.parent_ix);
              parent_d = LW'(in_d.parent_ix);
              state_d  = ST_APAR;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = IW'(head_q);
              parent_d = EndMark;
              state_d  = ST_AHEAD;
            end
          end else if (CW'(in_d.target_id) < NumC) begin
            rd_en   = 1'b1;
            rd_addr = IW'(in_d.target_id);
            cur_d   = IW'(in_d.target_id);
            freed_d = '0;
            state_d = ST_DEC;
          end else begin
            done       = 1'b1;
            res.status = STATUS_OK;
          end
        end
      end

      ST_APAR: begin
        // bump the parent, then fetch the free head (forwarded if equal)
        wr_en        = 1'b1;
        wr_addr      = IW'(parent_q);
        wr_entry     = rd_entry;
        wr_entry.cnt = rd_entry.cnt + GEN_W'(1);
        rd_en        = 1'b1;
        rd_addr      = IW'(head_q);
        state_d      = ST_AHEAD;
      end

      ST_AHEAD: begin
        wr_en         = 1'b1;
        wr_addr       = IW'(head_q);
        wr_entry.gen  = rd_entry.gen + GEN_W'(1);
        wr_entry.cnt  = GEN_W'(cnt_q);
        wr_entry.link = parent_q;
        head_d        = (rd_entry.link < EndMark) ? rd_entry.link : EndMark;
        done               = 1'b1;
        res.new_id         = ID_W'(head_q);
        res.new_generation = rd_entry.gen + GEN_W'(1);
        res.status         = STATUS_OK;
      end

      ST_DEC: begin
        if (rd_entry.cnt == '0) begin
          done            = 1'b1;
          res.status      = STATUS_ZERO;
          res.freed_count = FREED_W'(freed_q);
        end else if (cnt_dec != '0) begin
          wr_en           = 1'b1;
          wr_addr         = cur_q;
          wr_entry        = rd_entry;
          wr_entry.cnt    = cnt_dec;
          done            = 1'b1;
          res.status      = STATUS_OK;
          res.freed_count = FREED_W'(freed_q);
        end else begin
          // push on the free list, climb to the parent
          wr_en         = 1'b1;
          wr_addr       = cur_q;
          wr_entry.gen  = rd_entry.gen;
          wr_entry.cnt  = '0;
          wr_entry.link = head_q;
          head_d        = LW'(cur_q);
          freed_d       = freed_nx;
          if ((rd_entry.link < EndMark) && (freed_nx < EndMark)) begin
            rd_en   = 1'b1;
            rd_addr = IW'(rd_entry.link);
            cur_d   = IW'(rd_entry.link);
          end else begin
            done            = 1'b1;
            res.status      = STATUS_OK;
            res.freed_count = FREED_W'(freed_nx);
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (done) begin
      if (out_free) begin
        state_d = ST_IDLE;
      end else begin
        pend_d  = res;
        state_d = ST_RESP;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (done && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if ((state_q == ST_RESP) && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      head_q      <= '0;
      freed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      head_q      <= head_d;
      freed_q     <= freed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    parent_q   <= parent_d;
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
    pend_q     <= pend_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_resp_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |-> out_valid_q)
    else $error("pending response without a held output");

  a_alloc_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AHEAD) |-> (head_q < EndMark))
    else $error("allocation from an empty free list");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC) |-> (freed_q < EndMark))
    else $error("decrement walk ran past the pool size");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!out_valid_q && !s_axis_tready))
    else $error("traffic during the clearing pass");

endmodule

// ===== src/hct_mem.sv =====
// ----------------------------------------------------------------------------
// Tracker store
// Single-clock memory, one write and one read per cycle, registered read
// data. A read that hits the entry written in the same cycle returns the
// new data.
// ----------------------------------------------------------------------------
module hct_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 75
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ===== bench/hierarchical_completion_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical completion tracker testbench
// Drives allocate and decrement requests with random gaps and output stalls.
// A scoreboard keeps its own copy of the tracker pool and the free list,
// predicts one response per accepted request and checks every response.
// The run goes through a directed start, a pool fill with one long parent
// chain and its full collapse, random tree traffic with noise, and a
// decrement of a tracker that sits on the free list.
// ----------------------------------------------------------------------------
module hierarchical_completion_tracker_tb;
  import hct_pkg::*;

  localparam int POOL_SIZE    = 1024;
  localparam int END_MARK     = POOL_SIZE;
  localparam int RANDOM_ITEMS = 450;

  class tracker_scoreboard;
    logic [GEN_W-1:0] gen_q   [POOL_SIZE];
    logic [10:0]      link_q  [POOL_SIZE];
    logic [31:0]      count_q [POOL_SIZE];
    int unsigned      free_head;
    out_data_t        expected_q [$];
    int unsigned      errors, n_alloc, n_empty, n_dec, n_zero, max_freed;

    function new();
      for (int i = 0; i < POOL_SIZE; i++) begin
        gen_q[i]   = '0;
        count_q[i] = '0;
        link_q[i]  = 11'(i + 1);
      end
      free_head = 0;
      errors    = 0;
      n_alloc   = 0;
      n_empty   = 0;
      n_dec     = 0;
      n_zero    = 0;
      max_freed = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Update the pool for one accepted request and queue its response.
    function void note_request(op_e op, in_data_t req);
      out_data_t   rsp;
      int unsigned parent, id, cur, steps, up;
      rsp = '0;
      if (op == OP_ALLOC) begin
        n_alloc++;
        if (free_head >= POOL_SIZE) begin
          rsp.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          parent = END_MARK;
          if (req.has_parent && req.parent_ix < POOL_SIZE) begin
            parent = req.parent_ix;
            count_q[parent] = count_q[parent] + 1;
          end
          id = free_head;
          free_head = (link_q[id] < POOL_SIZE) ? link_q[id] : END_MARK;
          link_q[id]  = 11'(parent);
          count_q[id] = 32'(req.initial_count);
          gen_q[id]   = gen_q[id] + 1;
          rsp.new_id         = id[ID_W-1:0];
          rsp.new_generation = gen_q[id];
        end
      end else begin
        n_dec++;
        cur   = req.target_id;
        steps = 0;
        while (cur < POOL_SIZE && steps < POOL_SIZE) begin
          steps++;
          if (count_q[cur] == 0) begin
            rsp.status = STATUS_ZERO;
            n_zero++;
            break;
          end
          count_q[cur] = count_q[cur] - 1;
          if (count_q[cur] != 0) break;
          // read the parent before the push overwrites the link
          up = link_q[cur];
          link_q[cur] = 11'(free_head);
          free_head   = cur;
          rsp.freed_count = rsp.freed_count + 1;
          cur = up;
        end
        if (rsp.freed_count > max_freed) max_freed = rsp.freed_count;
      end
      expected_q.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(out_data_t got);
      out_data_t want;
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("new_id", 32'(want.new_id), 32'(got.new_id));
      compare_field("new_generation", want.new_generation, got.new_generation);
      compare_field("freed_count", 32'(want.freed_count), 32'(got.freed_count));
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  tracker_scoreboard sb = new();
  int unsigned       live_q [$];
  bit                sender_calm   = 1'b0;
  bit                receiver_calm = 1'b0;

  hierarchical_completion_tracker #(
    .POOL_SIZE(POOL_SIZE)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(op_e op, logic lp, logic [9:0] pid, logic [15:0] icnt,
                              logic [9:0] tid);
    in_data_t    req;
    int unsigned gap;
    req               = '0;
    req.has_parent    = lp;
    req.parent_ix     = pid;
    req.initial_count = icnt;
    req.target_id     = tid;
    gap = sender_calm ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_ALLOC && sb.free_head < POOL_SIZE) live_q.push_back(sb.free_head);
    sb.note_request(op, req);
  endtask

  // Hold the request side idle until every response is in.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Return a tracker that is still counting, dropping dead entries on the way.
  function automatic int pick_live();
    int unsigned idx, id;
    for (int tries = 0; tries < 8; tries++) begin
      if (live_q.size() == 0) return -1;
      idx = $urandom_range(0, live_q.size() - 1);
      id  = live_q[idx];
      if (sb.count_q[id] != 0) return id;
      live_q.delete(idx);
    end
    return -1;
  endfunction

  initial begin : response_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_response(m_axis_tdata);
    end
  end

  initial begin : stimulus
    int unsigned prev, id, guard;
    int          p, r;
    bit          have_prev;
    logic        lp;
    logic [15:0] icnt;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed start: extremes, zero counts, walks and a walk that hits a
    // freed parent.
    send_request(OP_ALLOC, 1'b0, 10'd1023, 16'hFFFF, 10'd0);
    send_request(OP_ALLOC, 1'b1, 10'd0, 16'd1, 10'd1023);
    send_request(OP_ALLOC, 1'b0, 10'd0, 16'd0, 10'd0);
    send_request(OP_DEC, 1'b1, 10'd1023, 16'hFFFF, 10'd2);
    send_request(OP_ALLOC, 1'b1, 10'd2, 16'd1, 10'd0);
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'd3);
    send_request(OP_ALLOC, 1'b0, 10'd0, 16'd0, 10'd1023);
    send_request(OP_ALLOC, 1'b1, 10'd2, 16'd2, 10'd0);
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'd2);
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'd3);
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'd3);
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'd1);
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'd1023);
    send_request(OP_ALLOC, 1'b1, 10'd1023, 16'd0, 10'd0);
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'd0);

    // Fill the pool with one chain, each tracker under the previous one,
    // the last one with a count of one, then hit the empty pool.
    have_prev = 1'b0;
    prev      = 0;
    guard     = 0;
    while (sb.free_head < POOL_SIZE && guard < 2 * POOL_SIZE) begin
      id   = sb.free_head;
      icnt = (sb.link_q[id] >= POOL_SIZE) ? 16'd1 : 16'd0;
      send_request(OP_ALLOC, have_prev, 10'(prev), icnt, 10'($urandom));
      prev      = id;
      have_prev = 1'b1;
      guard++;
    end
    repeat (2) send_request(OP_ALLOC, 1'($urandom), 10'($urandom), 16'($urandom),
                            10'($urandom));
    wait_drained();
    // Collapse the whole chain with one decrement of the leaf.
    send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'(prev));
    live_q.delete();

    // Random trees: mostly allocates under live parents and decrements of
    // live trackers, with some noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 2) wait_drained();
      r = $urandom_range(0, 99);
      p = pick_live();
      if (r < 45 || p < 0) begin
        lp   = (p >= 0) && ($urandom_range(0, 3) != 0);
        icnt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
        send_request(OP_ALLOC, lp, (p >= 0) ? 10'(p) : 10'($urandom), icnt,
                     10'($urandom));
      end else if (r < 90) begin
        send_request(OP_DEC, 1'($urandom), 10'($urandom), 16'($urandom), 10'(p));
      end else begin
        send_request(op_e'($urandom_range(0, 1)), 1'($urandom), 10'($urandom),
                     16'($urandom), 10'($urandom));
      end
    end

    // Give a tracker on the free list a count, then decrement it to zero
    // so it is pushed a second time.
    if (sb.free_head < POOL_SIZE && sb.link_q[sb.free_head] < POOL_SIZE) begin
      id = sb.link_q[sb.free_head];
      send_request(OP_ALLOC, 1'b1, 10'(id), 16'd1, 10'd0);
      send_request(OP_DEC, 1'b0, 10'd0, 16'd0, 10'(id));
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Run: %0d allocates, %0d of them on an empty pool; %0d decrements,",
             sb.n_alloc, sb.n_empty, sb.n_dec);
    $display("%0d of them on a zero count; longest walk freed %0d trackers.",
             sb.n_zero, sb.max_freed);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hct_pkg.sv
src/hct_mem.sv
src/hierarchical_completion_tracker.sv
bench/hierarchical_completion_tracker_tb.sv
